/* sv/rc4_pkg.sv */
// Package for the RC4 stream cipher core: sequencer states, op codes and
// fixed byte and permutation sizes. No dependencies.
`default_nettype none
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRD_J,
    ST_DSWAP,
    ST_DOUT,
    ST_KRD_N,
    ST_KRD_J,
    ST_KWR_N,
    ST_KWR_J
  } state_t;

endpackage
`default_nettype wire

/* sv/rc4_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read
// (read during write returns the old data). No dependencies.
`default_nettype none
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* sv/rc4_stream_cipher_core.sv */
// RC4 stream cipher top level: key store, permutation store, sequencer.
// Depends on rc4_pkg and rc4_ram.
`default_nettype none
// Key bytes (op 0) are taken back to back and fill the key store; a key byte
// with last set then runs the key schedule, 256 swap steps through KRD_N,
// KRD_J, KWR_N and KWR_J, during which item_ready is low. A data byte (op 1)
// passes through DRD_J, DSWAP and DOUT: the permutation memory is read three
// times in a dependent chain and written twice. The result sits in an output
// register, so one finished result can wait while the next item is taken.
// Before any key is loaded the permutation is the identity; it is held as
// valid bits over the memory, so reset and schedule start clear it at once.
module rc4_stream_cipher_core #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic       op,
  input  wire logic [7:0] byte_in,
  input  wire logic       last,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic      [7:0] out_byte
);

  localparam int KA = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int CW = $clog2(MAX_KEY_BYTES + 1);
  localparam int PA = $clog2(rc4_pkg::PERM_DEPTH);

  rc4_pkg::state_t state, state_next;

  logic [CW-1:0] key_count;
  logic [CW-1:0] key_len;
  logic [KA-1:0] k;
  logic [PA-1:0] n;
  logic [7:0]    index_i, index_j;
  logic [7:0]    a_q, b_q, t_q, data_q;
  logic [rc4_pkg::PERM_DEPTH-1:0] perm_valid;

  logic          pw_en;
  logic [PA-1:0] pw_addr, pr_addr, pr_addr_q;
  logic [7:0]    pw_data, pr_ram, pr_data;
  logic          pr_valid_q;
  logic [7:0]    key_rdata;
  logic          accept, key_we, sched_start, out_free;
  logic [CW-1:0] key_count_inc;
  logic [CW-1:0] k_inc;
  logic [7:0]    ks_byte;

  assign accept      = item_valid && item_ready;
  assign key_we      = accept && (op == rc4_pkg::OP_KEY) &&
                       (key_count < CW'(MAX_KEY_BYTES));
  assign sched_start = accept && (op == rc4_pkg::OP_KEY) && last;
  assign key_count_inc = key_we ? key_count + CW'(1) : key_count;
  assign k_inc       = CW'(k) + CW'(1);
  assign out_free    = !result_valid || result_ready;
  assign pr_data     = pr_valid_q ? pr_ram : pr_addr_q;

  always_comb begin
    if (t_q == index_j) begin
      ks_byte = a_q;
    end else if (t_q == index_i) begin
      ks_byte = b_q;
    end else begin
      ks_byte = pr_data;
    end
  end

  rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (pw_en),
    .waddr (pw_addr),
    .wdata (pw_data),
    .raddr (pr_addr),
    .rdata (pr_ram)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_count[KA-1:0]),
    .wdata (byte_in),
    .raddr (k),
    .rdata (key_rdata)
  );

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    pw_en      = 1'b0;
    pw_addr    = n;
    pw_data    = pr_data;
    pr_addr    = index_i + 8'd1;
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (op == rc4_pkg::OP_DATA) begin
            state_next = rc4_pkg::ST_DRD_J;
          end else if (last) begin
            state_next = rc4_pkg::ST_KRD_N;
          end
        end
      end
      rc4_pkg::ST_DRD_J: begin
        pr_addr    = index_j + pr_data;
        state_next = rc4_pkg::ST_DSWAP;
      end
      rc4_pkg::ST_DSWAP: begin
        pw_en      = 1'b1;
        pw_addr    = index_i;
        pw_data    = pr_data;
        pr_addr    = a_q + pr_data;
        state_next = rc4_pkg::ST_DOUT;
      end
      rc4_pkg::ST_DOUT: begin
        pw_en   = 1'b1;
        pw_addr = index_j;
        pw_data = a_q;
        pr_addr = t_q;
        if (out_free) begin
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_KRD_N: begin
        pr_addr    = n;
        state_next = rc4_pkg::ST_KRD_J;
      end
      rc4_pkg::ST_KRD_J: begin
        pr_addr    = index_j + pr_data + key_rdata;
        state_next = rc4_pkg::ST_KWR_N;
      end
      rc4_pkg::ST_KWR_N: begin
        pw_en      = 1'b1;
        pw_addr    = n;
        pw_data    = pr_data;
        state_next = rc4_pkg::ST_KWR_J;
      end
      rc4_pkg::ST_KWR_J: begin
        pw_en      = 1'b1;
        pw_addr    = index_j;
        pw_data    = a_q;
        state_next = (n == PA'(rc4_pkg::PERM_DEPTH - 1)) ? rc4_pkg::ST_IDLE
                                                         : rc4_pkg::ST_KRD_N;
      end
      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read data and its valid bit are sampled together, old-data semantics
  always_ff @(posedge clk) begin
    pr_addr_q  <= pr_addr;
    pr_valid_q <= perm_valid[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_valid <= '0;
    end else if (sched_start) begin
      perm_valid <= '0;
    end else if (pw_en) begin
      perm_valid[pw_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count    <= '0;
      index_i      <= '0;
      index_j      <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == rc4_pkg::ST_DOUT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        rc4_pkg::ST_IDLE: begin
          if (accept) begin
            if (op == rc4_pkg::OP_DATA) begin
              index_i <= index_i + 8'd1;
            end else if (last) begin
              key_count <= '0;
              index_j   <= '0;
            end else begin
              key_count <= key_count_inc;
            end
          end
        end
        rc4_pkg::ST_DRD_J: begin
          index_j <= index_j + pr_data;
        end
        rc4_pkg::ST_KRD_J: begin
          index_j <= index_j + pr_data + key_rdata;
        end
        rc4_pkg::ST_KWR_J: begin
          if (n == PA'(rc4_pkg::PERM_DEPTH - 1)) begin
            index_i <= '0;
            index_j <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        data_q <= byte_in;
        n      <= '0;
        k      <= '0;
        if (sched_start) begin
          key_len <= key_count_inc;
        end
      end
      rc4_pkg::ST_DRD_J: begin
        a_q <= pr_data;
      end
      rc4_pkg::ST_DSWAP: begin
        b_q <= pr_data;
        t_q <= a_q + pr_data;
      end
      rc4_pkg::ST_DOUT: begin
        if (out_free) begin
          out_byte <= data_q ^ ks_byte;
        end
      end
      rc4_pkg::ST_KRD_J: begin
        a_q <= pr_data;
      end
      rc4_pkg::ST_KWR_J: begin
        n <= n + PA'(1);
        k <= (k_inc >= key_len) ? '0 : k_inc[KA-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* tb/sv/rc4_stream_cipher_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rc4_stream_cipher_core: key and data beats over
// valid/ready, output bytes checked against a local RC4 predictor.
// Depends on rc4_pkg and the core RTL.
module rc4_stream_cipher_core_tb;

  localparam int WDOG_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 1100;
  localparam int PHASE_ITEMS  = 460;
  localparam int N_ROWS       = 20;

  typedef struct packed {
    logic       op_v;
    logic [7:0] data_v;
    logic       last_v;
    logic       fixed_v;
    logic [7:0] want_v;
  } stim_row_t;

  // fixed rows: first two data bytes after reset run over the identity
  stim_row_t stim_tab [N_ROWS] = '{
    '{rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
    '{rc4_pkg::OP_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA},
    '{rc4_pkg::OP_KEY,  8'h00, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_KEY,  8'h5A, 1'b1, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h7F, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_KEY,  8'h01, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h12, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_KEY,  8'h02, 1'b1, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{rc4_pkg::OP_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h55, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'hAA, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{rc4_pkg::OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00}
  };

  int idle_prof  [4] = '{0, 62, 0, 7};
  int stall_prof [4] = '{0, 0, 62, 7};

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       op           = rc4_pkg::OP_KEY;
  logic [7:0] byte_in      = 8'h00;
  logic       last         = 1'b0;
  logic       result_ready = 1'b0;
  logic       item_ready;
  logic       result_valid;
  logic [7:0] out_byte;

  logic [7:0]  perm_s    [256];
  logic [7:0]  key_bytes [256];
  int unsigned key_cnt;
  logic [7:0]  gen_i, gen_j;
  logic [7:0]  cipher_q [$];

  int   err_cnt       = 0;
  int   items_sent    = 0;
  int   n_key         = 0;
  int   n_data        = 0;
  int   n_sched       = 0;
  int   run_key       = 0;
  int   max_key       = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_cnt      = 0;
  int   idle_cycles   = 0;
  logic hold_req      = 1'b0;
  logic hold_done     = 1'b0;

  rc4_stream_cipher_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .byte_in      (byte_in),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic rc4_step(input logic o, input logic [7:0] b, input logic l,
                          output logic has_out, output logic [7:0] ob);
    logic [7:0] a, c, jj, t;
    int         n, kk;
    has_out = 1'b0;
    ob      = 8'h00;
    if (o == rc4_pkg::OP_KEY) begin
      if (key_cnt < 256) begin
        key_bytes[key_cnt] = b;
        key_cnt++;
      end
      if (l) begin
        for (n = 0; n < 256; n++) perm_s[n] = n[7:0];
        jj = 8'h00;
        kk = 0;
        for (n = 0; n < 256; n++) begin
          if (kk >= key_cnt) kk = 0;
          a         = perm_s[n];
          jj        = jj + a + key_bytes[kk];
          perm_s[n] = perm_s[jj];
          perm_s[jj] = a;
          kk++;
        end
        gen_i   = 8'h00;
        gen_j   = 8'h00;
        key_cnt = 0;
      end
    end else begin
      gen_i = gen_i + 8'd1;
      a     = perm_s[gen_i];
      gen_j = gen_j + a;
      c     = perm_s[gen_j];
      perm_s[gen_i] = c;
      perm_s[gen_j] = a;
      t       = a + c;
      ob      = b ^ perm_s[t];
      has_out = 1'b1;
    end
  endtask

  task automatic send_item(input logic o, input logic [7:0] b, input logic l,
                           input logic fixed, input logic [7:0] want);
    logic       has_out;
    logic [7:0] ob;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    byte_in    <= b;
    last       <= l;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    rc4_step(o, b, l, has_out, ob);
    if (has_out) cipher_q.push_back(fixed ? want : ob);
    items_sent++;
    if (o == rc4_pkg::OP_KEY) begin
      n_key++;
      run_key++;
      if (l) begin
        n_sched++;
        if (run_key > max_key) max_key = run_key;
        run_key = 0;
      end
    end else begin
      n_data++;
    end
  endtask

  // mostly clean key load + data run; some runs get stray data, last on data,
  // or a dropped last so the partial load carries into the next run
  task automatic send_sequence(input int force_len);
    int r, klen, dlen, k;
    bit noisy, drop;
    r = $urandom_range(99);
    if (force_len != 0) klen = force_len;
    else if (r < 70) klen = $urandom_range(16, 1);
    else if (r < 90) klen = $urandom_range(64, 17);
    else if (r < 97) klen = $urandom_range(256, 200);
    else klen = $urandom_range(300, 257);
    noisy = ($urandom_range(99) < 15);
    drop  = noisy && ($urandom_range(3) == 0);
    for (k = 0; k < klen; k++) begin
      if (noisy && $urandom_range(9) == 0)
        send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'b0, 8'h00);
      send_item(rc4_pkg::OP_KEY, 8'($urandom_range(255)), (k == klen - 1) && !drop,
                1'b0, 8'h00);
    end
    dlen = $urandom_range(40, 1);
    for (k = 0; k < dlen; k++)
      send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)),
                noisy && ($urandom_range(1) != 0), 1'b0, 8'h00);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (cipher_q.size() == 0) begin
          $error("out_byte: expected none, got %02h", out_byte);
          err_cnt++;
        end else begin
          if (out_byte !== cipher_q[0]) begin
            $error("out_byte: expected %02h, got %02h", cipher_q[0], out_byte);
            err_cnt++;
          end
          void'(cipher_q.pop_front());
        end
      end
      if (hold_req && !hold_done) begin
        hold_done    <= 1'b1;
        hold_cnt     <= HOLD_CYCLES;
        result_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt     <= hold_cnt - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
      $display("FAIL rc4_stream_cipher_core");
      $finish;
    end
  end

  initial begin
    int n, p;
    for (n = 0; n < 256; n++) begin
      perm_s[n]    = n[7:0];
      key_bytes[n] = 8'h00;
    end
    key_cnt = 0;
    gen_i   = 8'h00;
    gen_j   = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (stim_tab[r])
      send_item(stim_tab[r].op_v, stim_tab[r].data_v, stim_tab[r].last_v,
                stim_tab[r].fixed_v, stim_tab[r].want_v);
    send_sequence(258);
    for (p = 0; p < 4; p++) begin
      send_idle_pct = idle_prof[p];
      stall_pct     = stall_prof[p];
      while (items_sent < (p + 1) * PHASE_ITEMS) send_sequence(0);
    end
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req     <= 1'b1;
    repeat (24) send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)), 1'b0, 1'b0, 8'h00);
    item_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d key beats in %0d schedules (longest load %0d bytes), %0d data beats",
             n_key, n_sched, max_key, n_data);
    $display("phases: no idle, sender idle, receiver stall, mixed, long output hold-off");
    if (err_cnt == 0 && cipher_q.size() == 0) begin
      $display("PASS rc4_stream_cipher_core");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", err_cnt, cipher_q.size());
      $display("FAIL rc4_stream_cipher_core");
    end
    $finish;
  end

endmodule
